### rtl/adaptive_window_speed_estimator_assert.svh
// Assertion macros for the adaptive window speed estimator.
// Expects clk and arst_n in the scope of use.
`ifndef ADAPTIVE_WINDOW_SPEED_ESTIMATOR_ASSERT_SVH
`define ADAPTIVE_WINDOW_SPEED_ESTIMATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define AWSE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define AWSE_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
`else
`define AWSE_ASSERT(name, prop, msg)
`define AWSE_ASSERT_IMPL(name, ante, cons, msg)
`endif
`endif

### rtl/awse_pkg.sv
// Package of the adaptive window speed estimator: widths, codes, payload types.
// No dependencies.
`default_nettype none
package awse_pkg;
	localparam int RING_DEPTH_DEF = 50;
	localparam int DELTA_W = 16;
	localparam int SCALE_W = 16;
	localparam int ALPHA_W = 17;
	localparam int FRAC_W = 16;
	localparam int RATE_W = 24;
	localparam int LEN_W = 6;
	localparam int COUNT_W = 32;
	localparam int MUL_A_W = 26;
	localparam int MUL_B_W = 18;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 17;

	localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};
	localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_FLUSH = 2'd1;
	localparam logic [1:0] REQ_ZERO = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNTS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 3'd3;

	localparam logic [5:0] MIN_WINDOW_RST = 6'd8;
	localparam logic [14:0] MIN_COUNTS_RST = 15'd16;
	localparam logic [SCALE_W-1:0] SCALE_RST = 16'd640;
	localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd19661;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [COUNT_W-1:0] count;
	} item_t;

	typedef struct packed {
		logic [RATE_W-1:0] rate_filtered;
		logic [RATE_W-1:0] rate_raw;
		logic [LEN_W-1:0] window_len;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage
`default_nettype wire

### rtl/awse_chan_if.sv
// Valid/ready channel carrying one payload of type payload_t.
// No dependencies.
`default_nettype none
interface awse_chan_if #(parameter type payload_t = logic) ();
	logic valid;
	logic ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### rtl/awse_ring.sv
// Delta ring memory with per-entry valid bits; a read also returns the entry's valid bit.
// Uses awse_pkg.
`default_nettype none
module awse_ring #(
	parameter int DEPTH = awse_pkg::RING_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic clr,
	input  wire logic we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [awse_pkg::DELTA_W-1:0] wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [awse_pkg::DELTA_W-1:0] rdata,
	output logic rok
);
	import awse_pkg::*;

	logic [DELTA_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rok <= 1'b0;
		end else begin
			if (clr) begin
				vld_q <= '0;
			end else if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			rok <= vld_q[raddr];
		end
	end
endmodule
`default_nettype wire

### rtl/awse_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses awse_pkg.
`default_nettype none
module awse_div #(
	parameter int DVD_W = 40,
	parameter int DVS_W = 6
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [DVD_W-1:0] dividend,
	input  wire logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output awse_pkg::div_stat_t stat
);
	import awse_pkg::*;

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	logic [DVS_W:0] trial;
	logic [DVS_W:0] diff;
	logic qbit;

	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff = trial - {1'b0, dvs_q};
		qbit = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], qbit};
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign quotient = dvd_q;
	assign stat = '{busy: busy_q, done: done_q};
endmodule
`default_nettype wire

### rtl/adaptive_window_speed_estimator.sv
// Sample tick: a priming read and n ring reads, a multiply, a divide (37 quotient bits at
// RING_DEPTH 50), the filter multiply and add, then the output register (n = window
// length, at most 50); no new request is taken until the result has been handed on.
// Flush, zero or none request: the result goes straight to the output register.
// A result not yet taken by the sink holds the next one in its final state.
// Reset clears ring valid bits, ring head, anchor, filter state and restores registers.
`default_nettype none
`include "adaptive_window_speed_estimator_assert.svh"
module adaptive_window_speed_estimator #(
	parameter int RING_DEPTH = awse_pkg::RING_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	awse_chan_if.sink item,
	awse_chan_if.source result,
	awse_chan_if.sink cfg
);
	import awse_pkg::*;

	localparam int IDX_W = $clog2(RING_DEPTH);
	localparam int CNT_W = $clog2(RING_DEPTH + 1);
	localparam int SUM_W = DELTA_W + CNT_W;
	localparam int MAG_W = SUM_W - 1;
	localparam int PROD_W = MAG_W + SCALE_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_WALK = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_FILT = 7'b0010000,
		ST_FADD = 7'b0100000,
		ST_DONE = 7'b1000000
	} state_t;

	state_t st_q;

	logic [5:0] min_window_q;
	logic [14:0] min_counts_q;
	logic [SCALE_W-1:0] scale_q;
	logic [ALPHA_W-1:0] alpha_q;

	logic [IDX_W-1:0] head_q;
	logic [COUNT_W-1:0] anchor_q;
	logic [RATE_W-1:0] filt_q;
	logic [IDX_W-1:0] ptr_q;
	logic rd_pend_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] n_q;
	logic [MAG_W-1:0] mag_q;
	logic signed [MUL_P_W-1:0] mul_q;
	logic [RATE_W-1:0] raw_q;
	logic start_q;
	result_t res_q;
	result_t out_q;
	logic out_valid_q;

	logic acc;
	logic [1:0] req;
	logic ring_we;
	logic ring_clr;
	logic [DELTA_W-1:0] ring_wdata;
	logic [DELTA_W-1:0] rd_data;
	logic rd_ok;

	logic signed [SUM_W-1:0] d_ext;
	logic signed [SUM_W-1:0] sum_new;
	logic signed [SUM_W-1:0] sum_neg;
	logic [CNT_W-1:0] n_new;
	logic [MAG_W-1:0] mag_new;
	logic stop;

	logic [ALPHA_W-1:0] alpha_sat;
	logic signed [RATE_W:0] diff;
	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [MUL_P_W-1:0] mul_p;
	logic signed [MUL_A_W-1:0] fsum;
	logic [LEN_W-1:0] len;

	logic [PROD_W-1:0] quot;
	div_stat_t div_stat;
	logic slot_free;

	assign req = item.payload.req_type;
	assign item.ready = (st_q == ST_IDLE);
	assign acc = item.valid && item.ready;
	assign cfg.ready = 1'b1;

	assign ring_we = acc && (req == REQ_TICK);
	assign ring_clr = acc && ((req == REQ_FLUSH) || (req == REQ_ZERO));
	assign ring_wdata = DELTA_W'(item.payload.count - anchor_q);

	awse_ring #(.DEPTH(RING_DEPTH)) u_ring (
		.clk(clk),
		.arst_n(arst_n),
		.clr(ring_clr),
		.we(ring_we),
		.waddr(head_q),
		.wdata(ring_wdata),
		.raddr(ptr_q),
		.rdata(rd_data),
		.rok(rd_ok)
	);

	awse_div #(.DVD_W(PROD_W), .DVS_W(CNT_W)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(start_q),
		.dividend(mul_q[PROD_W-1:0]),
		.divisor(n_q),
		.quotient(quot),
		.stat(div_stat)
	);

	// window walk
	always_comb begin
		d_ext = rd_ok ? SUM_W'($signed(rd_data)) : '0;
		sum_new = sum_q + d_ext;
		sum_neg = -sum_new;
		n_new = n_q + CNT_W'(1);
		mag_new = sum_new[SUM_W-1] ? sum_neg[MAG_W-1:0] : sum_new[MAG_W-1:0];
		stop = ((32'(n_new) >= 32'(min_window_q)) && (32'(mag_new) >= 32'(min_counts_q)))
			|| (32'(n_new) == 32'(RING_DEPTH));
	end

	// shared multiplier: |sum|*scale, then alpha*(raw-filt)
	always_comb begin
		alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
		diff = $signed({1'b0, raw_q}) - $signed({1'b0, filt_q});
		if (st_q == ST_MUL) begin
			mul_a = $signed(MUL_A_W'(mag_q));
			mul_b = $signed(MUL_B_W'(scale_q));
		end else begin
			mul_a = MUL_A_W'(diff);
			mul_b = $signed(MUL_B_W'(alpha_sat));
		end
		mul_p = mul_a * mul_b;
		fsum = $signed({2'b00, filt_q}) + $signed(mul_q[FRAC_W+MUL_A_W-1:FRAC_W]);
		len = (32'(n_q) > 32'(LEN_MAX)) ? LEN_MAX : LEN_W'(n_q);
	end

	assign slot_free = !out_valid_q || result.ready;

	always_ff @(posedge clk) begin
		mul_q <= mul_p;
		if (st_q == ST_WALK && rd_pend_q && stop) begin
			mag_q <= mag_new;
		end
		if (st_q == ST_DIV && div_stat.done) begin
			raw_q <= (|quot[PROD_W-1:RATE_W]) ? RATE_MAX : quot[RATE_W-1:0];
		end
		if (acc) begin
			if (req == REQ_NONE) begin
				res_q <= '{rate_filtered: filt_q, rate_raw: '0, window_len: '0};
			end else begin
				res_q <= '0;
			end
		end else if (st_q == ST_FADD) begin
			res_q <= '{rate_filtered: fsum[RATE_W-1:0], rate_raw: raw_q, window_len: len};
		end
		if (st_q == ST_DONE && slot_free) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			head_q <= '0;
			anchor_q <= '0;
			filt_q <= '0;
			ptr_q <= '0;
			rd_pend_q <= 1'b0;
			sum_q <= '0;
			n_q <= '0;
			start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= (st_q == ST_MUL);
			if (st_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						priority if (req == REQ_TICK) begin
							anchor_q <= item.payload.count;
							head_q <= (32'(head_q) == RING_DEPTH - 1) ? '0 : head_q + IDX_W'(1);
							ptr_q <= head_q;
							sum_q <= '0;
							n_q <= '0;
							rd_pend_q <= 1'b0;
							st_q <= ST_WALK;
						end else if (req == REQ_NONE) begin
							st_q <= ST_DONE;
						end else begin
							anchor_q <= (req == REQ_FLUSH) ? item.payload.count : '0;
							head_q <= '0;
							filt_q <= '0;
							st_q <= ST_DONE;
						end
					end
				end
				ST_WALK: begin
					ptr_q <= (ptr_q == '0) ? IDX_W'(RING_DEPTH - 1) : ptr_q - IDX_W'(1);
					if (rd_pend_q) begin
						sum_q <= sum_new;
						n_q <= n_new;
						if (stop) begin
							rd_pend_q <= 1'b0;
							st_q <= ST_MUL;
						end
					end else begin
						rd_pend_q <= 1'b1;
					end
				end
				ST_MUL: begin
					st_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_stat.done) begin
						st_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					st_q <= ST_FADD;
				end
				ST_FADD: begin
					filt_q <= fsum[RATE_W-1:0];
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_window_q <= MIN_WINDOW_RST;
			min_counts_q <= MIN_COUNTS_RST;
			scale_q <= SCALE_RST;
			alpha_q <= ALPHA_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.payload.index)
				CFG_MIN_WINDOW: min_window_q <= cfg.payload.data[5:0];
				CFG_MIN_COUNTS: min_counts_q <= cfg.payload.data[14:0];
				CFG_SCALE: scale_q <= cfg.payload.data[SCALE_W-1:0];
				CFG_ALPHA: alpha_q <= cfg.payload.data[ALPHA_W-1:0];
				default: ;
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.payload = out_q;

	`AWSE_ASSERT(a_busy_after_req, (item.valid && item.ready) |=> !item.ready, "ready after request")
	`AWSE_ASSERT_IMPL(a_len_bound, result.valid, 32'(result.payload.window_len) <= RING_DEPTH, "window_len beyond ring")
	`AWSE_ASSERT_IMPL(a_raw_empty, result.valid && (result.payload.window_len == '0), result.payload.rate_raw == '0, "raw rate without window")
	`AWSE_ASSERT_IMPL(a_div_in_state, div_stat.done, st_q == ST_DIV, "divider done outside divide")
endmodule
`default_nettype wire

### tb/sv/adaptive_window_speed_estimator_tb.sv
// Testbench of the adaptive window speed estimator: a directed table, then random phases
// under changing settings; results checked against a speed predictor or the typed row.
// Depends on awse_pkg, awse_chan_if and the adaptive_window_speed_estimator RTL.
`default_nettype none
module adaptive_window_speed_estimator_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import awse_pkg::*;

	localparam int DEPTH = RING_DEPTH_DEF;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 110;
	localparam longint CYCLE_LIMIT = 1_000_000;

	typedef struct packed {
		logic [1:0] req;
		logic [COUNT_W-1:0] cnt;
		logic typed;
		result_t res;
	} step_row_t;

	localparam result_t NO_RATE = '{24'd0, 24'd0, 6'd0};

	localparam step_row_t PLAN [23] = '{
		'{REQ_TICK,  32'd0,          1'b1, '{24'd0, 24'd0, 6'd50}},
		'{REQ_TICK,  32'd100,        1'b0, NO_RATE},
		'{REQ_TICK,  32'd100,        1'b0, NO_RATE},
		'{REQ_TICK,  32'd300,        1'b0, NO_RATE},
		'{REQ_NONE,  32'hDEADBEEF,   1'b0, NO_RATE},
		'{REQ_FLUSH, 32'h7FFFFFFF,   1'b1, NO_RATE},
		'{REQ_TICK,  32'h80000000,   1'b0, NO_RATE},
		'{REQ_TICK,  32'h7FFFFFFF,   1'b0, NO_RATE},
		'{REQ_TICK,  32'h7FFF7FFF,   1'b0, NO_RATE},
		'{REQ_TICK,  32'hFFFF7FFF,   1'b0, NO_RATE},
		'{REQ_TICK,  32'hFFFFFFFE,   1'b0, NO_RATE},
		'{REQ_ZERO,  32'h12345678,   1'b1, NO_RATE},
		'{REQ_NONE,  32'hFFFFFFFF,   1'b1, NO_RATE},
		'{REQ_TICK,  32'hFFFFFFFF,   1'b0, NO_RATE},
		'{REQ_TICK,  32'd29999,      1'b0, NO_RATE},
		'{REQ_TICK,  32'd59999,      1'b0, NO_RATE},
		'{REQ_TICK,  32'd89999,      1'b0, NO_RATE},
		'{REQ_TICK,  32'd119999,     1'b0, NO_RATE},
		'{REQ_TICK,  32'd149999,     1'b0, NO_RATE},
		'{REQ_TICK,  32'd179999,     1'b0, NO_RATE},
		'{REQ_TICK,  32'd209999,     1'b0, NO_RATE},
		'{REQ_TICK,  32'd239999,     1'b0, NO_RATE},
		'{REQ_FLUSH, 32'd0,          1'b1, NO_RATE}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	awse_chan_if #(.payload_t(item_t)) item_ch ();
	awse_chan_if #(.payload_t(result_t)) result_ch ();
	awse_chan_if #(.payload_t(cfg_t)) cfg_ch ();

	adaptive_window_speed_estimator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg(cfg_ch)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [DELTA_W-1:0] hist_delta [DEPTH];
	int hist_ptr;
	logic signed [COUNT_W-1:0] last_count;
	logic [RATE_W-1:0] filt_rate;
	logic [5:0] win_min;
	logic [14:0] cnt_min;
	logic [SCALE_W-1:0] scale_reg;
	logic [ALPHA_W-1:0] gain_reg;

	result_t pending_rates [$];
	int fails = 0;
	int n_requests = 0;
	int n_checked = 0;
	int n_settings = 1;
	longint cycles = 0;
	bit calm = 1'b0;

	function automatic void clear_history(logic signed [COUNT_W-1:0] anchor);
		foreach (hist_delta[i])
			hist_delta[i] = '0;
		hist_ptr = 0;
		last_count = anchor;
		filt_rate = '0;
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			CFG_MIN_WINDOW: win_min = val[5:0];
			CFG_MIN_COUNTS: cnt_min = val[14:0];
			CFG_SCALE: scale_reg = val[15:0];
			CFG_ALPHA: gain_reg = val[16:0];
			default: ;
		endcase
	endfunction

	function automatic result_t estimate_speed(item_t it);
		result_t r;
		int n;
		int idx;
		int acc;
		bit stop;
		logic [31:0] mag;
		logic [63:0] raw;
		logic [63:0] f;
		logic [ALPHA_W-1:0] g;
		r = '0;
		case (it.req_type)
			REQ_FLUSH: clear_history(it.count);
			REQ_ZERO: clear_history('0);
			REQ_NONE: r.rate_filtered = filt_rate;
			default: begin
				hist_delta[hist_ptr] = DELTA_W'(it.count - last_count);
				last_count = it.count;
				hist_ptr = (hist_ptr == DEPTH - 1) ? 0 : hist_ptr + 1;
				acc = 0;
				n = 0;
				idx = hist_ptr;
				stop = 1'b0;
				while (n < DEPTH && !stop) begin
					idx = (idx == 0) ? DEPTH - 1 : idx - 1;
					acc += int'($signed(hist_delta[idx]));
					n++;
					mag = (acc < 0) ? -acc : acc;
					stop = (n >= win_min) && (mag >= cnt_min);
				end
				mag = (acc < 0) ? -acc : acc;
				raw = (64'(mag) * 64'(scale_reg)) / 64'(n);
				if (raw > RATE_MAX)
					raw = RATE_MAX;
				g = (gain_reg > ALPHA_ONE) ? ALPHA_ONE : gain_reg;
				f = (64'(g) * raw + 64'(ALPHA_ONE - g) * 64'(filt_rate)) >> FRAC_W;
				if (f > RATE_MAX)
					f = RATE_MAX;
				filt_rate = f[RATE_W-1:0];
				r.rate_filtered = filt_rate;
				r.rate_raw = raw[RATE_W-1:0];
				r.window_len = (n > LEN_MAX) ? LEN_MAX : LEN_W'(n);
			end
		endcase
		return r;
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_request(item_t it, logic typed, result_t typed_res);
		int gap;
		result_t want;
		gap = calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.payload <= it;
		do @(posedge clk); while (!item_ch.ready);
		want = estimate_speed(it);
		pending_rates.push_back(typed ? typed_res : want);
		n_requests++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.payload <= {idx, val};
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, val);
		@(negedge clk);
	endtask

	task automatic set_regs(int w, int c, int s, int a);
		write_reg(CFG_MIN_WINDOW, CFG_DATA_W'(w));
		write_reg(CFG_MIN_COUNTS, CFG_DATA_W'(c));
		write_reg(CFG_SCALE, CFG_DATA_W'(s));
		write_reg(CFG_ALPHA, CFG_DATA_W'(a));
		cfg_ch.valid <= 1'b0;
		n_settings++;
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (pending_rates.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic void check_rate(result_t got);
		result_t want;
		n_checked++;
		if (pending_rates.size() == 0) begin
			$error("unexpected result: filtered %0d raw %0d len %0d",
				got.rate_filtered, got.rate_raw, got.window_len);
			fails++;
			return;
		end
		want = pending_rates.pop_front();
		if (got.rate_filtered !== want.rate_filtered) begin
			$error("rate_filtered: expected %0d, got %0d", want.rate_filtered, got.rate_filtered);
			fails++;
		end
		if (got.rate_raw !== want.rate_raw) begin
			$error("rate_raw: expected %0d, got %0d", want.rate_raw, got.rate_raw);
			fails++;
		end
		if (got.window_len !== want.window_len) begin
			$error("window_len: expected %0d, got %0d", want.window_len, got.window_len);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycles, pending_rates.size());
			$display("** adaptive_window_speed_estimator: FAILED **");
			$finish;
		end
	end

	initial begin
		int stall;
		result_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			check_rate(result_ch.payload);
			@(negedge clk);
		end
	end

	initial begin
		item_t it;
		logic signed [COUNT_W-1:0] pos;
		int vel;
		int r;
		int d;
		item_ch.valid = 1'b0;
		item_ch.payload = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.payload = '0;
		win_min = MIN_WINDOW_RST;
		cnt_min = MIN_COUNTS_RST;
		scale_reg = SCALE_RST;
		gain_reg = ALPHA_RST;
		clear_history('0);
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (PLAN[i]) begin
			it.req_type = PLAN[i].req;
			it.count = PLAN[i].cnt;
			send_request(it, PLAN[i].typed, PLAN[i].res);
		end
		pos = '0;

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: set_regs(1, 0, 65535, 65536);
				1: set_regs(50, 32767, 0, 0);
				2: set_regs(0, 5, 1000, 131071);
				3: set_regs(63, 100, 256, 1);
				4: set_regs(MIN_WINDOW_RST, MIN_COUNTS_RST, SCALE_RST, ALPHA_RST);
				default: set_regs($urandom_range(1, 50),
					($urandom_range(0, 2) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 400),
					$urandom_range(0, 65535), $urandom_range(0, 65536));
			endcase
			calm = (p % 4 == 1);
			vel = int'($urandom_range(0, 60)) - 30;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				r = $urandom_range(0, 99);
				it.count = pos;
				if (r < 3) begin
					it.req_type = REQ_FLUSH;
					it.count = $urandom;
					pos = it.count;
				end else if (r < 5) begin
					it.req_type = REQ_ZERO;
					it.count = $urandom;
					pos = '0;
				end else if (r < 7) begin
					it.req_type = REQ_NONE;
					it.count = $urandom;
				end else begin
					it.req_type = REQ_TICK;
					case ($urandom_range(0, 9))
						6, 7: d = int'($urandom_range(0, 4000)) - 2000;
						8: d = int'($urandom_range(0, 65535)) - 32768;
						9: d = int'($urandom);
						default: d = vel + int'($urandom_range(0, 8)) - 4;
					endcase
					pos = pos + d;
					it.count = pos;
				end
				send_request(it, 1'b0, NO_RATE);
			end
		end

		drain();
		repeat (120) @(posedge clk);
		$display("%0d requests sent, %0d results checked, %0d register settings",
			n_requests, n_checked, n_settings);
		if (fails == 0)
			$display("** adaptive_window_speed_estimator: PASSED **");
		else
			$display("** adaptive_window_speed_estimator: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/awse_pkg.sv
rtl/awse_chan_if.sv
rtl/awse_ring.sv
rtl/awse_div.sv
rtl/adaptive_window_speed_estimator.sv
tb/sv/adaptive_window_speed_estimator_tb.sv
